// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define FPA_ASSERT_NEVER(lbl, clk, rstn, cond) \
    `FPA_ASSERT(lbl, clk, rstn, !(cond))
`else
`define FPA_ASSERT(lbl, clk, rstn, prop)
`define FPA_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: rtl/core/fpa_pkg.sv
package fpa_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int DATA_W     = 32;
    localparam int NUM_W      = DATA_W + FRAC_BITS;
    localparam int DIV_STAGES = DATA_W;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [31:0] MAX32 = 32'h7fff_ffff;
    localparam logic [31:0] MIN32 = 32'h8000_0000;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_MIN      = 4'd4,
        CMD_MAX      = 4'd5,
        CMD_INC      = 4'd6,
        CMD_DEC      = 4'd7,
        CMD_COMPARE  = 4'd8,
        CMD_TO_INT   = 4'd9,
        CMD_FROM_INT = 4'd10
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_SIMPLE = 2'd0,
        KIND_MUL    = 2'd1,
        KIND_DIV    = 2'd2
    } kind_t;

    // one classified item on its way from front to back
    typedef struct packed {
        kind_t              kind;
        logic [31:0]        value;
        logic               err;
        logic               gt;
        logic               lt;
        logic               eq;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } work_t;

endpackage

// File: rtl/core/fpa_front.sv
module fpa_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [3:0]          cmd,
    input  logic signed [31:0]  op_a,
    input  logic signed [31:0]  op_b,
    output logic                push,
    input  logic                q_full,
    output fpa_pkg::work_t      push_data
);

    logic           valid_reg;
    fpa_pkg::work_t work_reg;
    fpa_pkg::work_t work_next;

    // 33-bit sum back to 32 bits with saturation; returns {err, value}
    function automatic logic [32:0] sat33(input logic [32:0] s);
        if (s[32] != s[31]) begin
            return {1'b1, (s[32] ? fpa_pkg::MIN32 : fpa_pkg::MAX32)};
        end
        return {1'b0, s[31:0]};
    endfunction

    logic signed [32:0] ax;
    logic signed [32:0] bx;
    logic signed [31:0] hi_bits;
    logic [32:0]        sr;

    always_comb begin
        ax = {op_a[31], op_a};
        bx = {op_b[31], op_b};
        hi_bits = op_a >>> (fpa_pkg::DATA_W - 1 - fpa_pkg::FRAC_BITS);
        sr = '0;
        work_next.kind  = fpa_pkg::KIND_SIMPLE;
        work_next.value = '0;
        work_next.err   = 1'b0;
        work_next.gt    = op_a > op_b;
        work_next.lt    = op_a < op_b;
        work_next.eq    = op_a == op_b;
        work_next.a     = op_a;
        work_next.b     = op_b;
        case (fpa_pkg::cmd_t'(cmd))
            fpa_pkg::CMD_ADD: begin
                sr = sat33(33'(ax + bx));
                {work_next.err, work_next.value} = sr;
            end
            fpa_pkg::CMD_SUB: begin
                sr = sat33(33'(ax - bx));
                {work_next.err, work_next.value} = sr;
            end
            fpa_pkg::CMD_MUL: begin
                work_next.kind = fpa_pkg::KIND_MUL;
            end
            fpa_pkg::CMD_DIV: begin
                if (op_b == 32'sd0) begin
                    work_next.err = 1'b1;
                end else begin
                    work_next.kind = fpa_pkg::KIND_DIV;
                end
            end
            fpa_pkg::CMD_MIN: work_next.value = work_next.lt ? op_a : op_b;
            fpa_pkg::CMD_MAX: work_next.value = work_next.gt ? op_a : op_b;
            fpa_pkg::CMD_INC: begin
                sr = sat33(33'(ax + 33'sd1));
                {work_next.err, work_next.value} = sr;
            end
            fpa_pkg::CMD_DEC: begin
                sr = sat33(33'(ax - 33'sd1));
                {work_next.err, work_next.value} = sr;
            end
            fpa_pkg::CMD_COMPARE: work_next.value = '0;
            fpa_pkg::CMD_TO_INT:  work_next.value = op_a >>> fpa_pkg::FRAC_BITS;
            fpa_pkg::CMD_FROM_INT: begin
                // all bits shifted out plus the new sign bit must match the sign
                if (hi_bits != 32'sd0 && hi_bits != -32'sd1) begin
                    work_next.err   = 1'b1;
                    work_next.value = op_a[31] ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
                end else begin
                    work_next.value = op_a <<< fpa_pkg::FRAC_BITS;
                end
            end
            default: work_next.err = 1'b1;
        endcase
    end

    assign s_tready  = !valid_reg || !q_full;
    assign push      = valid_reg && !q_full;
    assign push_data = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            work_reg <= work_next;
        end
    end

endmodule

// File: rtl/core/fpa_queue.sv
`include "assert_macros.svh"

module fpa_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fpa_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output fpa_pkg::work_t head
);

    fpa_pkg::work_t                  mem [fpa_pkg::QDEPTH];
    logic [fpa_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [fpa_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [fpa_pkg::QCNT_W-1:0]      count_reg;

    assign full  = count_reg == fpa_pkg::QCNT_W'(fpa_pkg::QDEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `FPA_ASSERT_NEVER(a_q_overrun, aclk, aresetn, push && full)
    `FPA_ASSERT_NEVER(a_q_underrun, aclk, aresetn, pop && empty)
    `FPA_ASSERT(a_q_count_up, aclk, aresetn, push && !pop |=> count_reg == $past(count_reg) + 1'b1)

endmodule

// File: rtl/core/fpa_back.sv
`include "assert_macros.svh"

module fpa_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  fpa_pkg::work_t q_head,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    res_value,
    output logic           res_gt,
    output logic           res_lt,
    output logic           res_eq,
    output logic           res_err
);

    typedef struct packed {
        logic                valid;
        fpa_pkg::kind_t      kind;
        logic [31:0]         value;
        logic                err;
        logic                gt;
        logic                lt;
        logic                eq;
        logic                neg;
        logic                ovf;
        logic [31:0]         rem;
        logic [31:0]         num;   // numerator bits in, quotient bits out
        logic [31:0]         den;
    } stage_t;

    localparam logic [63:0] HALF = 64'd1 << (fpa_pkg::FRAC_BITS - 1);

    stage_t             st_reg [fpa_pkg::DIV_STAGES + 1];
    logic signed [63:0] prod_reg;
    logic               m_valid_reg;
    logic [35:0]        m_data_reg;
    logic               enable;

    // one restoring step: shift in a numerator bit, subtract if it fits
    function automatic stage_t div_step(input stage_t s);
        stage_t      r;
        logic [32:0] t;
        r = s;
        t = {s.rem, s.num[31]};
        if (s.kind == fpa_pkg::KIND_DIV && t >= {1'b0, s.den}) begin
            r.rem = 32'(t - {1'b0, s.den});
            r.num = {s.num[30:0], 1'b1};
        end else begin
            r.rem = t[31:0];
            r.num = {s.num[30:0], 1'b0};
        end
        return r;
    endfunction

    // sign a magnitude and saturate; returns {err, value}
    function automatic logic [32:0] sign_sat(input logic [63:0] m, input logic neg);
        if (neg) begin
            if (m > 64'h8000_0000) begin
                return {1'b1, fpa_pkg::MIN32};
            end
            return {1'b0, 32'(~m[31:0] + 32'd1)};
        end
        if (m > 64'h7fff_ffff) begin
            return {1'b1, fpa_pkg::MAX32};
        end
        return {1'b0, m[31:0]};
    endfunction

    assign enable = !m_valid_reg || m_tready;
    assign pop    = enable && !q_empty;

    // stage 0: set up divide, form product
    stage_t                         s0;
    logic [31:0]                    amag;
    logic [fpa_pkg::NUM_W-1:0]      nwide;

    always_comb begin
        amag  = q_head.a[31] ? 32'(~q_head.a + 32'd1) : q_head.a;
        nwide = {amag, {fpa_pkg::FRAC_BITS{1'b0}}};
        s0.valid = !q_empty;
        s0.kind  = q_head.kind;
        s0.value = q_head.value;
        s0.err   = q_head.err;
        s0.gt    = q_head.gt;
        s0.lt    = q_head.lt;
        s0.eq    = q_head.eq;
        s0.neg   = q_head.a[31] != q_head.b[31];
        s0.den   = q_head.b[31] ? 32'(~q_head.b + 32'd1) : q_head.b;
        s0.rem   = 32'(nwide[fpa_pkg::NUM_W-1:fpa_pkg::DATA_W]);
        s0.num   = nwide[fpa_pkg::DATA_W-1:0];
        // quotient needs more than 32 bits: saturate
        s0.ovf   = s0.rem >= s0.den;
    end

    // stage 1 also finishes the multiply
    stage_t      s1;
    logic [63:0] pmag;
    logic [63:0] pround;
    logic [32:0] msat;

    always_comb begin
        pmag   = prod_reg[63] ? 64'(~prod_reg + 64'd1) : prod_reg;
        pround = (pmag + HALF) >> fpa_pkg::FRAC_BITS;
        msat   = sign_sat(pround, prod_reg[63]);
        s1     = div_step(st_reg[0]);
        if (st_reg[0].kind == fpa_pkg::KIND_MUL) begin
            {s1.err, s1.value} = msat;
        end
    end

    // final rounding of the quotient
    stage_t      sl;
    logic        rnd;
    logic [32:0] q;
    logic [32:0] dsat;
    logic [31:0] fin_value;
    logic        fin_err;

    always_comb begin
        sl   = st_reg[fpa_pkg::DIV_STAGES];
        rnd  = {sl.rem, 1'b0} >= {1'b0, sl.den};
        q    = {1'b0, sl.num} + {32'd0, rnd};
        dsat = sign_sat({31'd0, q}, sl.neg);
        fin_value = sl.value;
        fin_err   = sl.err;
        if (sl.kind == fpa_pkg::KIND_DIV) begin
            if (sl.ovf) begin
                fin_err   = 1'b1;
                fin_value = sl.neg ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
            end else begin
                {fin_err, fin_value} = dsat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= fpa_pkg::DIV_STAGES; i++) begin
                st_reg[i].valid <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (enable) begin
            st_reg[0] <= s0;
            st_reg[1] <= s1;
            for (int i = 2; i <= fpa_pkg::DIV_STAGES; i++) begin
                st_reg[i] <= div_step(st_reg[i-1]);
            end
            m_valid_reg <= sl.valid;
        end
        if (enable) begin
            prod_reg   <= q_head.a * q_head.b;
            m_data_reg <= {fin_err, sl.eq, sl.lt, sl.gt, fin_value};
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign res_value = m_data_reg[31:0];
    assign res_gt    = m_data_reg[32];
    assign res_lt    = m_data_reg[33];
    assign res_eq    = m_data_reg[34];
    assign res_err   = m_data_reg[35];

    `FPA_ASSERT(a_flags_onehot, aclk, aresetn, m_valid_reg |-> $countones(m_data_reg[34:32]) == 1)
    `FPA_ASSERT(a_err_value, aclk, aresetn, m_valid_reg && res_err |-> res_value == fpa_pkg::MAX32 || res_value == fpa_pkg::MIN32 || res_value == 32'd0)
    `FPA_ASSERT_NEVER(a_pop_stall, aclk, aresetn, pop && !enable)

endmodule

// File: rtl/core/fixed_point_alu_q24_8.sv
// Signed Q24.8 fixed-point ALU.
// Input channel s_*: one item per handshake carrying command, operand_a and
// operand_b. Result channel m_*: one item per input item, in order, carrying
// result_value, greater, less, equal and error.
// Commands: add, sub, mul, div, min, max, inc, dec, compare, to_int, from_int.
// Mul and div round to nearest, halves away from zero; overflow saturates and
// sets error; divide by zero returns 0 with error; unknown codes return 0 with
// error.
// Throughput: one item per cycle, sustained while m_tready stays high.
// Every item passes the 32-stage restoring divider pipeline, plus front
// register, queue, setup and output register.
// A 4-entry queue sits between the classifying front end and the execute
// pipeline. When m_tready is low the pipeline holds, the queue fills, and
// s_tready drops only once queue and front register are full; nothing is lost.
// Reset (aresetn low, synchronous) empties all stages and the queue.
module fixed_point_alu_q24_8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] command, [35:4] operand_a, [67:36] operand_b, [71:68] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] result_value, [32] greater, [33] less, [34] equal, [35] error,
    // [39:36] zero
    output logic [39:0] m_tdata
);

    logic           push;
    logic           q_full;
    logic           q_empty;
    logic           pop;
    fpa_pkg::work_t push_data;
    fpa_pkg::work_t q_head;
    logic [31:0]    res_value;
    logic           res_gt;
    logic           res_lt;
    logic           res_eq;
    logic           res_err;

    fpa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cmd       (s_tdata[3:0]),
        .op_a      (s_tdata[35:4]),
        .op_b      (s_tdata[67:36]),
        .push      (push),
        .q_full    (q_full),
        .push_data (push_data)
    );

    fpa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    fpa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res_value (res_value),
        .res_gt    (res_gt),
        .res_lt    (res_lt),
        .res_eq    (res_eq),
        .res_err   (res_err)
    );

    assign m_tdata = {4'd0, res_err, res_eq, res_lt, res_gt, res_value};

endmodule
